/* sv/tcp_segment_header_builder_macros.svh */
// Assertion macros shared by the header builder checkers.
// No dependencies; include once per file that asserts.
`ifndef TCP_SEGMENT_HEADER_BUILDER_MACROS_SVH
`define TCP_SEGMENT_HEADER_BUILDER_MACROS_SVH

// implication checked in the same cycle, muted while reset is high
`define TSHB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication checked in the next cycle, muted while reset is high
`define TSHB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// implication checked in the next cycle, active during reset
`define TSHB_ASSERT_RAW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/tshb_pkg.sv */
// Types, constants and checksum helpers for the TCP segment header builder.
// No dependencies; used by the top level and its checker.
package tshb_pkg;

  localparam logic [10:0] MAX_SEGMENT   = 11'd1460;
  localparam logic [10:0] SEG_HDR_BYTES = 11'd40;
  localparam logic [10:0] TCP_HDR_BYTES = 11'd20;

  localparam logic [15:0] IP_VER_TOS    = 16'h4500;
  localparam logic [15:0] IP_ID         = 16'h1234;
  localparam logic [15:0] IP_TTL_PROTO  = 16'h4006;
  localparam logic [15:0] PROTO_TCP     = 16'h0006;
  localparam logic [15:0] TCP_OFF_FLAGS = 16'h5010;
  localparam logic [15:0] TCP_WINDOW    = 16'h2000;

  localparam logic [17:0] IP_FIXED_SUM = 18'(IP_VER_TOS) + 18'(SEG_HDR_BYTES)
                                       + 18'(IP_ID) + 18'(IP_TTL_PROTO);
  localparam logic [16:0] TCP_FIXED_SUM = 17'(PROTO_TCP) + 17'(TCP_HDR_BYTES)
                                        + 17'(TCP_OFF_FLAGS) + 17'(TCP_WINDOW);

  typedef enum logic [1:0] {
    REG_CLIENT_ADDR = 2'd0,
    REG_SERVER_ADDR = 2'd1,
    REG_CLIENT_PORT = 2'd2,
    REG_SERVER_PORT = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       from_client;
    logic       write_end;
  } in_item_t;

  typedef struct packed {
    logic [10:0] ip_total_length;
    logic [15:0] ip_checksum;
    logic [31:0] source_addr;
    logic [31:0] dest_addr;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [31:0] seq_number;
    logic [31:0] ack_number;
    logic [15:0] tcp_checksum;
    logic [10:0] payload_length;
    logic        segment_client;
  } out_item_t;

  function automatic logic [15:0] oc_add16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  function automatic logic [15:0] oc_fold21(input logic [20:0] s);
    logic [16:0] f;
    f = {1'b0, s[15:0]} + {12'd0, s[20:16]};
    return f[15:0] + {15'd0, f[16]};
  endfunction

endpackage

/* sv/tcp_segment_header_builder.sv */
// Top level of the TCP segment header builder for one flow.
// Depends on tshb_pkg for item types, register codes and checksum helpers.
//
// Payload bytes stream in at one byte per cycle; a running ones-complement
// sum, the held high byte and the segment byte count advance on every
// transfer. A segment closes on write_end or at MAX_SEGMENT bytes, and its
// header reaches the output through a segment register (sequence numbers
// and a partial TCP sum) and then a result register (the address, port and
// payload terms folded into both checksums). Throughput is one byte per
// cycle while input ready is high; input ready drops only while both
// registers hold headers that the output has not taken. Configuration
// writes are taken in any cycle and must happen while no segment is open
// or in flight.
module tcp_segment_header_builder (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tshb_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tshb_pkg::out_item_t  out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  tshb_pkg::reg_index_t cfg_index,
  input  logic [31:0]          cfg_data
);

  logic [31:0] client_addr;
  logic [31:0] server_addr;
  logic [15:0] client_port;
  logic [15:0] server_port;

  logic [15:0] payload_sum;
  logic [7:0]  held_high_byte;
  logic [10:0] segment_count;
  logic [31:0] client_seq;
  logic [31:0] server_seq;

  logic        seg_valid;
  logic [10:0] seg_len;
  logic [15:0] seg_psum;
  logic        seg_client;
  logic [31:0] seg_seq;
  logic [31:0] seg_ack;
  logic [18:0] seg_part;

  logic        out_load;
  logic        in_fire;
  logic        seg_close;
  logic [10:0] count_inc;
  logic [15:0] pair_word;
  logic [15:0] sum_next;
  logic [31:0] seq_sel;
  logic [31:0] ack_sel;
  logic [18:0] part_next;

  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [15:0] src_port;
  logic [15:0] dst_port;
  logic [20:0] ip_sum;
  logic [20:0] tcp_sum;

  assign cfg_ready = 1'b1;
  assign out_load  = !out_valid || out_ready;
  assign in_ready  = !seg_valid || out_load;
  assign in_fire   = in_valid && in_ready;

  // byte path
  always_comb begin
    count_inc = segment_count + 11'd1;
    pair_word = segment_count[0] ? {held_high_byte, in_item.data_byte}
                                 : {in_item.data_byte, 8'h00};
    sum_next  = tshb_pkg::oc_add16(payload_sum, pair_word);
    seg_close = in_item.write_end || (count_inc >= tshb_pkg::MAX_SEGMENT);
    seq_sel   = in_item.from_client ? client_seq : server_seq;
    ack_sel   = in_item.from_client ? server_seq : client_seq;
    part_next = 19'(seq_sel[31:16]) + 19'(seq_sel[15:0])
              + 19'(ack_sel[31:16]) + 19'(ack_sel[15:0])
              + 19'(count_inc) + 19'(tshb_pkg::TCP_FIXED_SUM);
  end

  // header path
  always_comb begin
    src_addr = seg_client ? client_addr : server_addr;
    dst_addr = seg_client ? server_addr : client_addr;
    src_port = seg_client ? client_port : server_port;
    dst_port = seg_client ? server_port : client_port;
    ip_sum   = 21'(tshb_pkg::IP_FIXED_SUM) + 21'(seg_len)
             + 21'(src_addr[31:16]) + 21'(src_addr[15:0])
             + 21'(dst_addr[31:16]) + 21'(dst_addr[15:0]);
    tcp_sum  = 21'(seg_part)
             + 21'(client_addr[31:16]) + 21'(client_addr[15:0])
             + 21'(server_addr[31:16]) + 21'(server_addr[15:0])
             + 21'(src_port) + 21'(dst_port) + 21'(seg_psum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      client_addr <= '0;
      server_addr <= '0;
      client_port <= '0;
      server_port <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tshb_pkg::REG_CLIENT_ADDR: client_addr <= cfg_data;
        tshb_pkg::REG_SERVER_ADDR: server_addr <= cfg_data;
        tshb_pkg::REG_CLIENT_PORT: client_port <= cfg_data[15:0];
        tshb_pkg::REG_SERVER_PORT: server_port <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_sum    <= '0;
      held_high_byte <= '0;
      segment_count  <= '0;
      client_seq     <= '0;
      server_seq     <= '0;
    end else if (in_fire) begin
      if (seg_close) begin
        payload_sum    <= '0;
        held_high_byte <= '0;
        segment_count  <= '0;
        if (in_item.from_client) begin
          client_seq <= client_seq + 32'(count_inc);
        end else begin
          server_seq <= server_seq + 32'(count_inc);
        end
      end else begin
        segment_count <= count_inc;
        if (segment_count[0]) begin
          payload_sum <= sum_next;
        end else begin
          held_high_byte <= in_item.data_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_valid <= 1'b0;
    end else if (in_ready) begin
      seg_valid <= in_fire && seg_close;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && seg_close) begin
      seg_len    <= count_inc;
      seg_psum   <= sum_next;
      seg_client <= in_item.from_client;
      seg_seq    <= seq_sel;
      seg_ack    <= ack_sel;
      seg_part   <= part_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= seg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && seg_valid) begin
      out_item.ip_total_length <= seg_len + tshb_pkg::SEG_HDR_BYTES;
      out_item.ip_checksum     <= ~tshb_pkg::oc_fold21(ip_sum);
      out_item.source_addr     <= src_addr;
      out_item.dest_addr       <= dst_addr;
      out_item.source_port     <= src_port;
      out_item.dest_port       <= dst_port;
      out_item.seq_number      <= seg_seq;
      out_item.ack_number      <= seg_ack;
      out_item.tcp_checksum    <= ~tshb_pkg::oc_fold21(tcp_sum);
      out_item.payload_length  <= seg_len;
      out_item.segment_client  <= seg_client;
    end
  end

endmodule

/* sv/tshb_checker.sv */
// Port-level checker for the TCP segment header builder, bound to the top.
// Depends on tshb_pkg and tcp_segment_header_builder_macros.svh.
`include "tcp_segment_header_builder_macros.svh"

module tshb_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input tshb_pkg::out_item_t out_item
);

  `TSHB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item), "stalled header changed")
  `TSHB_ASSERT_NOW(a_len_match, out_valid, out_item.ip_total_length == out_item.payload_length + tshb_pkg::SEG_HDR_BYTES, "total length mismatch")
  `TSHB_ASSERT_NOW(a_len_range, out_valid, out_item.payload_length != 11'd0 && out_item.payload_length <= tshb_pkg::MAX_SEGMENT, "payload length out of range")
  `TSHB_ASSERT_RAW(a_reset_idle, rst, !out_valid, "header shown after reset")

endmodule

bind tcp_segment_header_builder tshb_checker u_tshb_checker (.*);

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking bench for tcp_segment_header_builder: payload bytes in, one header per segment.
// Needs tshb_pkg and the builder RTL; a behavioral segment tracker predicts every header field.
module tb_top;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_MOSTLY, RX_BEAT} rx_pace_t;

  localparam int IDLE_LIMIT = 4000;
  localparam int LONG_HOLD  = 300;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  tshb_pkg::in_item_t   in_item = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  tshb_pkg::out_item_t  out_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  tshb_pkg::reg_index_t cfg_index = tshb_pkg::REG_CLIENT_ADDR;
  logic [31:0]          cfg_data = '0;

  tshb_pkg::in_item_t  byte_q[$];
  tshb_pkg::out_item_t header_q[$];

  logic [31:0] flow_cli_addr = '0;
  logic [31:0] flow_srv_addr = '0;
  logic [15:0] flow_cli_port = '0;
  logic [15:0] flow_srv_port = '0;
  logic [31:0] pair_sum = '0;
  logic [7:0]  held_hi = '0;
  logic [10:0] seg_len = '0;
  logic [31:0] cli_bytes = '0;
  logic [31:0] srv_bytes = '0;

  int fail_count = 0;
  int hdrs_seen = 0;
  int hold_left = 0;
  int burst_left = 1;
  int gap_left = 0;
  int idle_cycles = 0;
  logic [5:0] pace_cnt = '0;
  rx_pace_t   pace = RX_OPEN;

  tcp_segment_header_builder dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [15:0] fold16(input logic [31:0] raw);
    logic [31:0] s;
    s = raw;
    while (s[31:16] != 0) s = s[15:0] + s[31:16];
    return s[15:0];
  endfunction

  task automatic track_segment(input tshb_pkg::in_item_t b);
    tshb_pkg::out_item_t h;
    logic [31:0] src, dst, seq, ack, pay, acc;
    logic [15:0] sp, dp;
    logic [10:0] len;
    if (!seg_len[0]) held_hi = b.data_byte;
    else pair_sum = pair_sum + {held_hi, b.data_byte};
    seg_len = seg_len + 11'd1;
    if (!b.write_end && seg_len < tshb_pkg::MAX_SEGMENT) return;
    len = seg_len;
    pay = pair_sum;
    if (len[0]) pay = pay + {held_hi, 8'h00};
    if (b.from_client) begin
      src = flow_cli_addr; dst = flow_srv_addr;
      sp = flow_cli_port;  dp = flow_srv_port;
      seq = cli_bytes;     ack = srv_bytes;
      cli_bytes = cli_bytes + len;
    end else begin
      src = flow_srv_addr; dst = flow_cli_addr;
      sp = flow_srv_port;  dp = flow_cli_port;
      seq = srv_bytes;     ack = cli_bytes;
      srv_bytes = srv_bytes + len;
    end
    acc = 32'h4500 + (len + 32'd40) + 32'h1234 + 32'h4006
        + src[31:16] + src[15:0] + dst[31:16] + dst[15:0];
    h.ip_checksum = ~fold16(acc);
    acc = flow_cli_addr[31:16] + flow_cli_addr[15:0] + flow_srv_addr[31:16]
        + flow_srv_addr[15:0] + 32'd6 + (len + 32'd20) + sp + dp
        + seq[31:16] + seq[15:0] + ack[31:16] + ack[15:0]
        + 32'h5010 + 32'h2000 + pay;
    h.tcp_checksum    = ~fold16(acc);
    h.ip_total_length = len + 11'd40;
    h.source_addr     = src;
    h.dest_addr       = dst;
    h.source_port     = sp;
    h.dest_port       = dp;
    h.seq_number      = seq;
    h.ack_number      = ack;
    h.payload_length  = len;
    h.segment_client  = b.from_client;
    header_q.push_back(h);
    seg_len = '0;
    pair_sum = '0;
    held_hi = '0;
  endtask

  function automatic int field_bad(input string nm, input logic [31:0] want,
                                   input logic [31:0] got);
    if (want === got) return 0;
    $display("%0t: %s expected %h got %h", $time, nm, want, got);
    return 1;
  endfunction

  // payload side: bursts with random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) track_segment(in_item);
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (byte_q.size() != 0) begin
          in_item <= byte_q.pop_front();
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 14)
                                                   : $urandom_range(0, 2);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // header side: compare and pace
  always @(posedge clk) begin : rx_side
    tshb_pkg::out_item_t want;
    int bad;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (header_q.size() == 0) begin
          $display("%0t: header expected none got %h", $time, out_item);
          fail_count++;
        end else begin
          want = header_q.pop_front();
          bad = 0;
          bad += field_bad("ip_total_length", 32'(want.ip_total_length),
                           32'(out_item.ip_total_length));
          bad += field_bad("ip_checksum", 32'(want.ip_checksum),
                           32'(out_item.ip_checksum));
          bad += field_bad("source_addr", want.source_addr, out_item.source_addr);
          bad += field_bad("dest_addr", want.dest_addr, out_item.dest_addr);
          bad += field_bad("source_port", 32'(want.source_port),
                           32'(out_item.source_port));
          bad += field_bad("dest_port", 32'(want.dest_port), 32'(out_item.dest_port));
          bad += field_bad("seq_number", want.seq_number, out_item.seq_number);
          bad += field_bad("ack_number", want.ack_number, out_item.ack_number);
          bad += field_bad("tcp_checksum", 32'(want.tcp_checksum),
                           32'(out_item.tcp_checksum));
          bad += field_bad("payload_length", 32'(want.payload_length),
                           32'(out_item.payload_length));
          bad += field_bad("segment_client", 32'(want.segment_client),
                           32'(out_item.segment_client));
          fail_count += bad;
        end
        hdrs_seen++;
        if (hdrs_seen == 30 || hdrs_seen == 70) hold_left = LONG_HOLD;
      end
      pace_cnt <= pace_cnt + 6'd1;
      if (pace_cnt == '0) pace <= rx_pace_t'($urandom_range(0, 3));
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (pace)
          RX_OPEN:   out_ready <= 1'b1;
          RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
          RX_MOSTLY: out_ready <= ($urandom_range(0, 7) != 0);
          default:   out_ready <= pace_cnt[2];
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic program_flow(input logic [31:0] ca, input logic [31:0] sa,
                              input logic [31:0] cp, input logic [31:0] sp);
    logic [31:0]          vals [4];
    tshb_pkg::reg_index_t order [4];
    vals  = '{ca, sa, cp, sp};
    order = '{tshb_pkg::REG_CLIENT_ADDR, tshb_pkg::REG_SERVER_ADDR,
              tshb_pkg::REG_CLIENT_PORT, tshb_pkg::REG_SERVER_PORT};
    @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= order[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      case (order[i])
        tshb_pkg::REG_CLIENT_ADDR: flow_cli_addr = vals[i];
        tshb_pkg::REG_SERVER_ADDR: flow_srv_addr = vals[i];
        tshb_pkg::REG_CLIENT_PORT: flow_cli_port = vals[i][15:0];
        default:                   flow_srv_port = vals[i][15:0];
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (byte_q.size() != 0 || in_valid || header_q.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic queue_write(input int len, input logic dir, input int flip_at);
    tshb_pkg::in_item_t it;
    for (int k = 0; k < len; k++) begin
      it.data_byte   = 8'($urandom_range(0, 255));
      it.from_client = (flip_at >= 0 && k >= flip_at) ? ~dir : dir;
      it.write_end   = (k == len - 1);
      byte_q.push_back(it);
    end
  endtask

  task automatic queue_random_writes(input int n_bytes);
    int queued, len, pick, flip;
    queued = 0;
    while (queued < n_bytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) len = $urandom_range(1, 6);
      else if (pick < 97) len = $urandom_range(7, 30);
      else len = $urandom_range(31, 120);
      flip = -1;
      if (len > 1 && $urandom_range(0, 9) == 0) flip = $urandom_range(1, len - 1);
      queue_write(len, 1'($urandom_range(0, 1)), flip);
      queued += len;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    byte_q.push_back({8'h00, 1'b1, 1'b1});
    byte_q.push_back({8'hff, 1'b0, 1'b1});
    byte_q.push_back({8'hff, 1'b1, 1'b0});
    byte_q.push_back({8'hff, 1'b1, 1'b1});
    byte_q.push_back({8'h80, 1'b0, 1'b0});
    byte_q.push_back({8'h01, 1'b0, 1'b0});
    byte_q.push_back({8'h7f, 1'b0, 1'b1});
    // direction flips inside a segment: closing byte decides the side
    byte_q.push_back({8'h12, 1'b1, 1'b0});
    byte_q.push_back({8'h34, 1'b1, 1'b0});
    byte_q.push_back({8'h56, 1'b0, 1'b1});
    byte_q.push_back({8'ha5, 1'b0, 1'b0});
    byte_q.push_back({8'h5a, 1'b1, 1'b1});
    drain();

    program_flow(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    @(negedge clk);
    queue_random_writes(150);
    drain();

    program_flow($urandom(), $urandom(), $urandom(), $urandom());
    @(negedge clk);
    queue_random_writes(250);
    drain();

    program_flow($urandom(), $urandom(), $urandom(), $urandom());
    @(negedge clk);
    queue_random_writes(150);
    drain();

    program_flow(32'h0, 32'h0, 32'h0, 32'h0);
    @(negedge clk);
    queue_random_writes(150);
    drain();

    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
